### hdl/icpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpr_pkg
// Shared widths, register indexes, reset values and the configuration bundle
// of the cascaded IIR PI regulator.
// ----------------------------------------------------------------------------
package icpr_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int VAL_FRAC_BITS      = 16;

    localparam int COEF_W  = 32;
    localparam int LIM_W   = 16;
    localparam int SMP_W   = 16;
    localparam int ERR_W   = SMP_W + 1;
    localparam int VAL_W   = 48;
    localparam int SUM_W   = VAL_W + 1;
    localparam int CHUNK_W = 24;
    localparam int OPB_W   = 26;
    localparam int PROD_W  = COEF_W + OPB_W;
    localparam int ACC_W   = 84;
    localparam int CLAMP_W = LIM_W + VAL_FRAC_BITS + 1;
    localparam int DIFF_W  = CLAMP_W + 1;

    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_FIRST_FEEDBACK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_GAIN_NOW   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_GAIN_PAST  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SECOND_FEEDBACK  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SECOND_GAIN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_LOOP_GAIN        = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRIVE_LOW_LIMIT  = 3'd6;
    localparam logic [IDX_W-1:0] REG_DRIVE_HIGH_LIMIT = 3'd7;

    localparam logic signed [COEF_W-1:0] RST_FIRST_FEEDBACK  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] RST_FIRST_GAIN_NOW  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] RST_FIRST_GAIN_PAST = -32'sd65536;
    localparam logic signed [COEF_W-1:0] RST_SECOND_FEEDBACK = 32'sd65536;
    localparam logic signed [COEF_W-1:0] RST_SECOND_GAIN     = 32'sd205887;
    localparam logic signed [COEF_W-1:0] RST_LOOP_GAIN       = 32'sd65536;
    localparam logic signed [LIM_W-1:0]  RST_DRIVE_LOW_LIMIT  = -16'sd32768;
    localparam logic signed [LIM_W-1:0]  RST_DRIVE_HIGH_LIMIT = 16'sd32767;

    typedef struct packed {
        logic signed [COEF_W-1:0] first_feedback;
        logic signed [COEF_W-1:0] first_gain_now;
        logic signed [COEF_W-1:0] first_gain_past;
        logic signed [COEF_W-1:0] second_feedback;
        logic signed [COEF_W-1:0] second_gain;
        logic signed [COEF_W-1:0] loop_gain;
        logic signed [LIM_W-1:0]  drive_low_limit;
        logic signed [LIM_W-1:0]  drive_high_limit;
    } cfg_t;

endpackage

### hdl/icpr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpr_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module icpr_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [icpr_pkg::APB_AW-1:0]    paddr,
    input  logic [icpr_pkg::APB_DW-1:0]    pwdata,
    output logic [icpr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output icpr_pkg::cfg_t                 cfg
);

    icpr_pkg::cfg_t               cfg_reg;
    logic [icpr_pkg::IDX_W-1:0]   idx;
    logic                         wr_en;

    assign idx    = paddr[icpr_pkg::APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_feedback   <= icpr_pkg::RST_FIRST_FEEDBACK;
            cfg_reg.first_gain_now   <= icpr_pkg::RST_FIRST_GAIN_NOW;
            cfg_reg.first_gain_past  <= icpr_pkg::RST_FIRST_GAIN_PAST;
            cfg_reg.second_feedback  <= icpr_pkg::RST_SECOND_FEEDBACK;
            cfg_reg.second_gain      <= icpr_pkg::RST_SECOND_GAIN;
            cfg_reg.loop_gain        <= icpr_pkg::RST_LOOP_GAIN;
            cfg_reg.drive_low_limit  <= icpr_pkg::RST_DRIVE_LOW_LIMIT;
            cfg_reg.drive_high_limit <= icpr_pkg::RST_DRIVE_HIGH_LIMIT;
        end
        else if (wr_en)
        begin
            case (idx)
                icpr_pkg::REG_FIRST_FEEDBACK:   cfg_reg.first_feedback  <= pwdata;
                icpr_pkg::REG_FIRST_GAIN_NOW:   cfg_reg.first_gain_now  <= pwdata;
                icpr_pkg::REG_FIRST_GAIN_PAST:  cfg_reg.first_gain_past <= pwdata;
                icpr_pkg::REG_SECOND_FEEDBACK:  cfg_reg.second_feedback <= pwdata;
                icpr_pkg::REG_SECOND_GAIN:      cfg_reg.second_gain     <= pwdata;
                icpr_pkg::REG_LOOP_GAIN:        cfg_reg.loop_gain       <= pwdata;
                icpr_pkg::REG_DRIVE_LOW_LIMIT:
                    cfg_reg.drive_low_limit  <= pwdata[icpr_pkg::LIM_W-1:0];
                icpr_pkg::REG_DRIVE_HIGH_LIMIT:
                    cfg_reg.drive_high_limit <= pwdata[icpr_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            icpr_pkg::REG_FIRST_FEEDBACK:   prdata = cfg_reg.first_feedback;
            icpr_pkg::REG_FIRST_GAIN_NOW:   prdata = cfg_reg.first_gain_now;
            icpr_pkg::REG_FIRST_GAIN_PAST:  prdata = cfg_reg.first_gain_past;
            icpr_pkg::REG_SECOND_FEEDBACK:  prdata = cfg_reg.second_feedback;
            icpr_pkg::REG_SECOND_GAIN:      prdata = cfg_reg.second_gain;
            icpr_pkg::REG_LOOP_GAIN:        prdata = cfg_reg.loop_gain;
            icpr_pkg::REG_DRIVE_LOW_LIMIT:
                prdata = icpr_pkg::APB_DW'(cfg_reg.drive_low_limit);
            icpr_pkg::REG_DRIVE_HIGH_LIMIT:
                prdata = icpr_pkg::APB_DW'(cfg_reg.drive_high_limit);
            default: prdata = '0;
        endcase
    end

endmodule

### hdl/icpr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpr_mul
// Shared signed 32 x 26 multiplier with a registered product.
// ----------------------------------------------------------------------------
module icpr_mul
(
    input  logic                                 clk,
    input  logic signed [icpr_pkg::COEF_W-1:0]   op_a,
    input  logic signed [icpr_pkg::OPB_W-1:0]    op_b,
    output logic signed [icpr_pkg::PROD_W-1:0]   prod
);

    logic signed [icpr_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= icpr_pkg::PROD_W'(op_a) * icpr_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### hdl/icpr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpr_engine
// Sequencer, accumulator and filter state; feeds the shared multiplier with
// 24-bit slices of the 48-bit values and holds the output register.
// ----------------------------------------------------------------------------
module icpr_engine
#(
    parameter int COEF_FRAC_BITS = icpr_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  icpr_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [icpr_pkg::SMP_W-1:0]    measured,
    input  logic signed [icpr_pkg::SMP_W-1:0]    setpoint,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [icpr_pkg::LIM_W-1:0]    drive,
    output logic signed [icpr_pkg::COEF_W-1:0]   mul_a,
    output logic signed [icpr_pkg::OPB_W-1:0]    mul_b,
    input  logic signed [icpr_pkg::PROD_W-1:0]   mul_p
);

    localparam int VW  = icpr_pkg::VAL_W;
    localparam int AW  = icpr_pkg::ACC_W;
    localparam int CW  = icpr_pkg::CHUNK_W;
    localparam int BW  = icpr_pkg::OPB_W;
    localparam int EW  = icpr_pkg::ERR_W;
    localparam int LW  = icpr_pkg::LIM_W;
    localparam int KW  = icpr_pkg::CLAMP_W;
    localparam int DW  = icpr_pkg::DIFF_W;
    localparam int FB  = icpr_pkg::VAL_FRAC_BITS;
    localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE     = DW'(1) <<< FB;
    localparam logic signed [KW-1:0] ROUND_UP = KW'((1 << FB) - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_Y1_A, ST_Y1_B, ST_Y1_C, ST_Y1_D, ST_Y1_E, ST_Y1_S,
        ST_Y2_A, ST_Y2_B, ST_Y2_C, ST_Y2_D, ST_Y2_S,
        ST_G_A, ST_G_B, ST_G_C, ST_G_S, ST_CLAMP, ST_OUT
    } state_t;

    state_t                     state_reg;
    logic                       out_valid_reg;
    logic signed [LW-1:0]       drive_reg;
    logic signed [LW-1:0]       last_drive_reg;
    logic signed [EW-1:0]       prev_error_reg;
    logic signed [VW-1:0]       first_prev_out_reg;
    logic signed [VW-1:0]       second_prev_out_reg;

    logic signed [EW-1:0]       error_reg;
    logic signed [AW-1:0]       acc_reg;
    logic signed [VW-1:0]       y1_reg;
    logic signed [VW-1:0]       g_reg;
    logic signed [KW-1:0]       clamp_reg;

    logic signed [AW-1:0]       acc_next;
    logic signed [AW-1:0]       prod_ext;
    logic signed [AW-1:0]       shifted;
    logic signed [VW-1:0]       sat_val;
    logic signed [icpr_pkg::SUM_W-1:0] y1_sum;
    logic signed [VW-1:0]       hi_lim;
    logic signed [VW-1:0]       lo_lim;
    logic signed [VW-1:0]       g_upper;
    logic signed [VW-1:0]       g_clamped;
    logic signed [DW-1:0]       diff;
    logic signed [DW-1:0]       diff_abs;
    logic                       emit;
    logic signed [KW-1:0]       trunc_base;
    logic signed [LW-1:0]       quotient;
    logic                       accept;
    logic                       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Operand selection for the shared multiplier.
    assign y1_sum = icpr_pkg::SUM_W'(first_prev_out_reg) + icpr_pkg::SUM_W'(y1_reg);

    always_comb
    begin
        case (state_reg)
            ST_Y1_A:
            begin
                mul_a = cfg.first_feedback;
                mul_b = {2'b00, first_prev_out_reg[CW-1:0]};
            end
            ST_Y1_B:
            begin
                mul_a = cfg.first_feedback;
                mul_b = BW'($signed(first_prev_out_reg[VW-1:CW]));
            end
            ST_Y1_C:
            begin
                mul_a = cfg.first_gain_past;
                mul_b = BW'(prev_error_reg);
            end
            ST_Y1_D:
            begin
                mul_a = cfg.first_gain_now;
                mul_b = BW'(error_reg);
            end
            ST_Y1_S:
            begin
                mul_a = cfg.second_feedback;
                mul_b = {2'b00, second_prev_out_reg[CW-1:0]};
            end
            ST_Y2_A:
            begin
                mul_a = cfg.second_feedback;
                mul_b = BW'($signed(second_prev_out_reg[VW-1:CW]));
            end
            ST_Y2_B:
            begin
                mul_a = cfg.second_gain;
                mul_b = {2'b00, y1_sum[CW-1:0]};
            end
            ST_Y2_C:
            begin
                mul_a = cfg.second_gain;
                mul_b = BW'($signed(y1_sum[icpr_pkg::SUM_W-1:CW]));
            end
            ST_G_A:
            begin
                mul_a = cfg.loop_gain;
                mul_b = {2'b00, second_prev_out_reg[CW-1:0]};
            end
            ST_G_B:
            begin
                mul_a = cfg.loop_gain;
                mul_b = BW'($signed(second_prev_out_reg[VW-1:CW]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The product arriving now belongs to the operands of the previous state.
    assign prod_ext = AW'(mul_p);

    always_comb
    begin
        case (state_reg)
            ST_Y1_B, ST_Y2_A, ST_Y2_C, ST_G_B:
                acc_next = acc_reg + prod_ext;
            ST_Y1_C, ST_Y2_B, ST_Y2_D, ST_G_C:
                acc_next = acc_reg + (prod_ext <<< CW);
            ST_Y1_D, ST_Y1_E:
                acc_next = acc_reg + (prod_ext <<< FB);
            ST_Y1_A, ST_Y1_S, ST_Y2_S:
                acc_next = '0;
            default:
                acc_next = acc_reg;
        endcase
    end

    // Arithmetic shift of the exact sum, then saturation to 48 bits.
    assign shifted = acc_reg >>> COEF_FRAC_BITS;

    always_comb
    begin
        if ((&shifted[AW-1:VW-1]) || !(|shifted[AW-1:VW-1]))
        begin
            sat_val = shifted[VW-1:0];
        end
        else if (shifted[AW-1])
        begin
            sat_val = SAT_MIN;
        end
        else
        begin
            sat_val = SAT_MAX;
        end
    end

    // Upper bound first, then the lower bound, so a crossed pair favours the low limit.
    assign hi_lim    = VW'(cfg.drive_high_limit) <<< FB;
    assign lo_lim    = VW'(cfg.drive_low_limit) <<< FB;
    assign g_upper   = (g_reg > hi_lim) ? hi_lim : g_reg;
    assign g_clamped = (g_upper < lo_lim) ? lo_lim : g_upper;

    assign diff       = DW'(clamp_reg) - (DW'(last_drive_reg) <<< FB);
    assign diff_abs   = diff[DW-1] ? -diff : diff;
    assign emit       = diff_abs > ONE;
    assign trunc_base = clamp_reg[KW-1] ? (clamp_reg + ROUND_UP) : clamp_reg;
    assign quotient   = trunc_base[FB+LW-1:FB];

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (accept)
        begin
            error_reg <= EW'(measured) - EW'(setpoint);
        end
        if (state_reg == ST_Y1_S)
        begin
            y1_reg <= sat_val;
        end
        if (state_reg == ST_G_S)
        begin
            g_reg <= sat_val;
        end
        if (state_reg == ST_CLAMP)
        begin
            clamp_reg <= g_clamped[KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            out_valid_reg       <= 1'b0;
            drive_reg           <= '0;
            last_drive_reg      <= '0;
            prev_error_reg      <= '0;
            first_prev_out_reg  <= '0;
            second_prev_out_reg <= '0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:  if (accept) state_reg <= ST_Y1_A;
                ST_Y1_A:  state_reg <= ST_Y1_B;
                ST_Y1_B:  state_reg <= ST_Y1_C;
                ST_Y1_C:  state_reg <= ST_Y1_D;
                ST_Y1_D:  state_reg <= ST_Y1_E;
                ST_Y1_E:  state_reg <= ST_Y1_S;
                ST_Y1_S:  state_reg <= ST_Y2_A;
                ST_Y2_A:  state_reg <= ST_Y2_B;
                ST_Y2_B:  state_reg <= ST_Y2_C;
                ST_Y2_C:  state_reg <= ST_Y2_D;
                ST_Y2_D:  state_reg <= ST_Y2_S;
                ST_Y2_S:
                begin
                    prev_error_reg      <= error_reg;
                    first_prev_out_reg  <= y1_reg;
                    second_prev_out_reg <= sat_val;
                    state_reg           <= ST_G_A;
                end
                ST_G_A:   state_reg <= ST_G_B;
                ST_G_B:   state_reg <= ST_G_C;
                ST_G_C:   state_reg <= ST_G_S;
                ST_G_S:   state_reg <= ST_CLAMP;
                ST_CLAMP: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (emit)
                        begin
                            drive_reg      <= quotient;
                            last_drive_reg <= quotient;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("Input taken again before the current item finished.");

    a_emit_only_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("Output raised outside the output step.");

    a_drive_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg == last_drive_reg))
        else $error("Pending drive differs from the stored last drive.");

    a_state_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Y2_S) |=> (second_prev_out_reg == $past(sat_val)))
        else $error("Second section state not committed.");
`endif

endmodule

### hdl/iir_cascade_pi_regulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_cascade_pi_regulator_core
// Cascaded first-order IIR PI regulator: zero-pole and pole-only sections,
// overall gain, clamp and change detection on the drive value.
//
// Each transfer on the slave stream carries one measured sample and its
// setpoint. The error runs through both sections and the gain on a single
// shared 32 x 26 multiplier; ten partial products plus saturation, clamp and
// compare steps keep s_tready low from acceptance until the last step is
// left, so items are taken one at a time. A drive result, when the change
// exceeds 1.0, is loaded into the output register in that last step; items
// that change the drive by 1.0 or less produce no transfer.
// The output register lets a new item be taken while a result waits; if the
// receiver still holds off m_tready when the next item reaches its last step,
// the sequencer waits in that step until the register is free.
// Coefficients must be written over APB only while the block is idle; the
// block does not enforce this. Reset clears the filter history and the last
// drive, loads the default coefficients and leaves the block idle and ready.
// ----------------------------------------------------------------------------
module iir_cascade_pi_regulator_core
#(
    parameter int COEF_FRAC_BITS = icpr_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [icpr_pkg::APB_AW-1:0]       paddr,
    input  logic [icpr_pkg::APB_DW-1:0]       pwdata,
    output logic [icpr_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*icpr_pkg::SMP_W-1:0]      s_tdata,   // measured, setpoint
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [icpr_pkg::LIM_W-1:0]        m_tdata    // drive
);

    icpr_pkg::cfg_t                             cfg;
    logic signed [icpr_pkg::COEF_W-1:0]         mul_a;
    logic signed [icpr_pkg::OPB_W-1:0]          mul_b;
    logic signed [icpr_pkg::PROD_W-1:0]         mul_p;
    logic signed [icpr_pkg::LIM_W-1:0]          drive;

    assign m_tdata = drive;

    icpr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    icpr_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    icpr_engine
    #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .measured  (s_tdata[icpr_pkg::SMP_W-1:0]),
        .setpoint  (s_tdata[2*icpr_pkg::SMP_W-1:icpr_pkg::SMP_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (drive),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p)
    );

endmodule
